// ----- sv/dltq_pkg.sv -----
// shared types, codes and defaults of the delta list timer queue
package dltq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int DELAY_BITS_DEF  = 16;
  localparam int MAX_RESULTS     = 16;

  localparam int HND_W  = 8;
  localparam int ARG_W  = 32;
  localparam int KIND_W = 2;
  localparam int PEND_W = 5;
  localparam int NEXP_W = $clog2(MAX_RESULTS + 1);

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [KIND_W-1:0] EV_ADD_OK   = 2'd0;
  localparam logic [KIND_W-1:0] EV_ADD_FULL = 2'd1;
  localparam logic [KIND_W-1:0] EV_EXPIRED  = 2'd2;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    logic gt;
    logic zero;
    logic borrow;
  } alu_flags_t;

endpackage

// ----- sv/dltq_ram.sv -----
// generic single write port, single read port ram with registered read
module dltq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/dltq_alu.sv -----
// shared delta adder and subtractor with compare against a limit
module dltq_alu
  import dltq_pkg::*;
#(
  parameter int DELAY_BITS = DELAY_BITS_DEF
) (
  input  alu_op_e               op_i,
  input  logic [DELAY_BITS-1:0] a_i,
  input  logic [DELAY_BITS-1:0] b_i,
  input  logic [DELAY_BITS-1:0] lim_i,
  output logic [DELAY_BITS-1:0] res_o,
  output alu_flags_t            flags_o
);

  logic [DELAY_BITS:0] wide;

  always_comb begin
    unique case (op_i)
      ALU_ADD: wide = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: wide = {1'b0, a_i} - {1'b0, b_i};
      default: wide = '0;
    endcase
  end

  assign res_o          = wide[DELAY_BITS-1:0];
  assign flags_o.gt     = wide > {1'b0, lim_i};
  assign flags_o.zero   = (wide[DELAY_BITS-1:0] == '0);
  assign flags_o.borrow = (op_i == ALU_SUB) && wide[DELAY_BITS];

endmodule

// ----- sv/delta_list_timer_queue_unit.sv -----
// top level of the delta list timer queue
// Timer queue kept as a delta list sorted by expiry, stored in a ring buffer in one ram
// (head pointer plus count, so an expiry pops in one step). One adder/subtractor is shared
// by a small sequencer. The block takes one transaction at a time; in_stall_o is high
// while a transaction is being worked on. An add walks the list at one entry a cycle to
// find its slot, forms the remaining delay in S_REST, moves every entry behind the
// slot up by one at one entry a cycle, then writes the new task. A full queue answers
// with a reject. A tick with an empty queue gives no result and does not stall at all;
// a tick whose head is not yet due only counts the head down and gives no result. A tick
// that expires m tasks (at most 16) gives m results: each further due entry needs one
// ram read before the previous result can be marked last. After a stall the next
// transaction is taken once the sequencer is back in S_IDLE. Results wait in an output
// register, so a downstream stall holds the sequencer in the state that emits a result.
module delta_list_timer_queue_unit
  import dltq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int DELAY_BITS  = DELAY_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [DELAY_BITS-1:0] delay_ticks_i,
  input  logic [HND_W-1:0]      handler_id_i,
  input  logic [ARG_W-1:0]      task_argument_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KIND_W-1:0]     event_kind_o,
  output logic [HND_W-1:0]      expired_handler_o,
  output logic [ARG_W-1:0]      expired_argument_o,
  output logic [PEND_W-1:0]     pending_count_o,
  output logic                  last_o
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int AW    = IDX_W + 1;
  localparam int ENT_W = DELAY_BITS + HND_W + ARG_W;

  localparam logic [AW-1:0]    DEPTH_A = AW'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FIND = 4'd1;  // walk deltas to find the slot
  localparam logic [3:0] S_REST = 4'd2;  // remaining delay at the slot
  localparam logic [3:0] S_SHRD = 4'd3;  // first read of the tail entry
  localparam logic [3:0] S_SHWR = 4'd4;  // move entries up, one a cycle
  localparam logic [3:0] S_INS  = 4'd5;  // write new task, report accept
  localparam logic [3:0] S_REJ  = 4'd6;  // report queue full
  localparam logic [3:0] S_TICK = 4'd7;  // count down or expire the head
  localparam logic [3:0] S_PEEK = 4'd8;  // read the new head
  localparam logic [3:0] S_EXP  = 4'd9;  // new head due or not
  localparam logic [3:0] S_LAST = 4'd10; // final expiry of this tick

  // logical slot to ram address, wrapping around the ring
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] l);
    logic [AW-1:0] s;
    s = AW'(head) + AW'(l);
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[IDX_W-1:0];
  endfunction

  logic [3:0]            state_q, state_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      scan_q, scan_d;   // walk index, then move source
  logic [CNT_W-1:0]      pos_q, pos_d;     // slot of the new task
  logic [DELAY_BITS-1:0] acc_q, acc_d;     // sum of deltas passed
  logic [DELAY_BITS-1:0] rest_q, rest_d;   // delay left at the slot
  logic [NEXP_W-1:0]     nexp_q, nexp_d;   // expiries on this tick

  // latched request payload
  logic [DELAY_BITS-1:0] delay_q, delay_d;
  logic [HND_W-1:0]      hnd_q, hnd_d;
  logic [ARG_W-1:0]      arg_q, arg_d;

  // expired task held until its last flag is known
  logic [HND_W-1:0]      pend_hnd_q, pend_hnd_d;
  logic [ARG_W-1:0]      pend_arg_q, pend_arg_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [KIND_W-1:0]     kind_q, kind_d;
  logic [HND_W-1:0]      ohnd_q, ohnd_d;
  logic [ARG_W-1:0]      oarg_q, oarg_d;
  logic [PEND_W-1:0]     opend_q, opend_d;
  logic                  olast_q, olast_d;

  // ram port
  logic                  rd_en;
  logic [CNT_W-1:0]      rd_l;
  logic [ENT_W-1:0]      rd_data;
  logic                  wr_en;
  logic [CNT_W-1:0]      wr_l;
  logic [ENT_W-1:0]      wr_data;

  // shared unit
  alu_op_e               alu_op;
  logic [DELAY_BITS-1:0] alu_a, alu_b, alu_lim, alu_res;
  alu_flags_t            alu_flags;

  logic [DELAY_BITS-1:0] rd_delta;
  logic [HND_W-1:0]      rd_hnd;
  logic [ARG_W-1:0]      rd_arg;
  logic                  in_accept;
  logic                  out_free;

  assign rd_delta = rd_data[ENT_W-1 -: DELAY_BITS];
  assign rd_hnd   = rd_data[ARG_W +: HND_W];
  assign rd_arg   = rd_data[ARG_W-1:0];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // output slot can take a new result this cycle
  assign out_free   = !out_valid_q || !out_stall_i;

  dltq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (phys(head_q, wr_l)),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (phys(head_q, rd_l)),
    .rd_data_o (rd_data)
  );

  dltq_alu #(
    .DELAY_BITS (DELAY_BITS)
  ) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .lim_i   (alu_lim),
    .res_o   (alu_res),
    .flags_o (alu_flags)
  );

  always_comb begin
    logic [CNT_W-1:0] scan_n;
    logic [CNT_W-1:0] cnt_m1;
    logic             emit;
    logic [KIND_W-1:0] e_kind;
    logic [HND_W-1:0]  e_hnd;
    logic [ARG_W-1:0]  e_arg;
    logic [CNT_W-1:0]  e_pend;
    logic              e_last;

    scan_n = scan_q + 1'b1;
    cnt_m1 = count_q - 1'b1;

    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    scan_d     = scan_q;
    pos_d      = pos_q;
    acc_d      = acc_q;
    rest_d     = rest_q;
    nexp_d     = nexp_q;
    delay_d    = delay_q;
    hnd_d      = hnd_q;
    arg_d      = arg_q;
    pend_hnd_d = pend_hnd_q;
    pend_arg_d = pend_arg_q;

    rd_en   = 1'b0;
    rd_l    = '0;
    wr_en   = 1'b0;
    wr_l    = '0;
    wr_data = rd_data;

    alu_op  = ALU_ADD;
    alu_a   = acc_q;
    alu_b   = rd_delta;
    alu_lim = delay_q;

    emit   = 1'b0;
    e_kind = EV_EXPIRED;
    e_hnd  = pend_hnd_q;
    e_arg  = pend_arg_q;
    e_pend = count_q;
    e_last = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        // keep the head entry in the read register for a tick
        rd_en = 1'b1;
        rd_l  = '0;
        if (in_accept) begin
          delay_d = delay_ticks_i;
          hnd_d   = handler_id_i;
          arg_d   = task_argument_i;
          if (req_type_i == REQ_TICK) begin
            if (count_q != '0) begin
              state_d = S_TICK;
            end
          end else if (count_q == DEPTH_C) begin
            state_d = S_REJ;
          end else begin
            acc_d  = '0;
            scan_d = '0;
            if (count_q == '0) begin
              pos_d   = '0;
              state_d = S_REST;
            end else begin
              state_d = S_FIND;
            end
          end
        end
      end

      S_FIND: begin
        // acc + delta > delay: new task goes in front of this entry
        if (alu_flags.gt) begin
          pos_d   = scan_q;
          state_d = S_REST;
        end else begin
          acc_d = alu_res;
          if (scan_n == count_q) begin
            pos_d   = count_q;
            state_d = S_REST;
          end else begin
            scan_d = scan_n;
            rd_en  = 1'b1;
            rd_l   = scan_n;
          end
        end
      end

      S_REST: begin
        alu_op = ALU_SUB;
        alu_a  = delay_q;
        alu_b  = acc_q;
        rest_d = alu_res;
        if (pos_q == count_q) begin
          state_d = S_INS;
        end else begin
          scan_d  = cnt_m1;
          state_d = S_SHRD;
        end
      end

      S_SHRD: begin
        rd_en   = 1'b1;
        rd_l    = scan_q;
        state_d = S_SHWR;
      end

      S_SHWR: begin
        // entry at scan moves up one slot; the one at the new slot loses the rest
        alu_op = ALU_SUB;
        alu_a  = rd_delta;
        alu_b  = rest_q;
        wr_en  = 1'b1;
        wr_l   = scan_n;
        if (scan_q == pos_q) begin
          wr_data = {alu_res, rd_hnd, rd_arg};
          state_d = S_INS;
        end else begin
          scan_d = scan_q - 1'b1;
          rd_en  = 1'b1;
          rd_l   = scan_q - 1'b1;
        end
      end

      S_INS: begin
        if (out_free) begin
          wr_en   = 1'b1;
          wr_l    = pos_q;
          wr_data = {rest_q, hnd_q, arg_q};
          count_d = count_q + 1'b1;
          emit    = 1'b1;
          e_kind  = EV_ADD_OK;
          e_hnd   = '0;
          e_arg   = '0;
          e_pend  = count_q + 1'b1;
          e_last  = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_REJ: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = EV_ADD_FULL;
          e_hnd   = '0;
          e_arg   = '0;
          e_last  = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_TICK: begin
        // head delta minus one; a borrow or a zero means the head is due
        alu_op = ALU_SUB;
        alu_a  = rd_delta;
        alu_b  = DELAY_BITS'(1);
        if (!(alu_flags.borrow || alu_flags.zero)) begin
          wr_en   = 1'b1;
          wr_l    = '0;
          wr_data = {alu_res, rd_hnd, rd_arg};
          state_d = S_IDLE;
        end else begin
          pend_hnd_d = rd_hnd;
          pend_arg_d = rd_arg;
          head_d     = phys(head_q, CNT_W'(1));
          count_d    = cnt_m1;
          nexp_d     = NEXP_W'(1);
          if (cnt_m1 == '0 || NEXP_W'(1) == NEXP_W'(MAX_RESULTS)) begin
            state_d = S_LAST;
          end else begin
            state_d = S_PEEK;
          end
        end
      end

      S_PEEK: begin
        rd_en   = 1'b1;
        rd_l    = '0;
        state_d = S_EXP;
      end

      S_EXP: begin
        alu_op = ALU_SUB;
        alu_a  = rd_delta;
        alu_b  = '0;
        if (out_free) begin
          emit = 1'b1;
          if (alu_flags.zero) begin
            // new head due too: the held result is not the last one
            pend_hnd_d = rd_hnd;
            pend_arg_d = rd_arg;
            head_d     = phys(head_q, CNT_W'(1));
            count_d    = cnt_m1;
            nexp_d     = nexp_q + 1'b1;
            if (cnt_m1 == '0 || (nexp_q + 1'b1) == NEXP_W'(MAX_RESULTS)) begin
              state_d = S_LAST;
            end else begin
              state_d = S_PEEK;
            end
          end else begin
            e_last  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end

      S_LAST: begin
        if (out_free) begin
          emit    = 1'b1;
          e_last  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // output register
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    ohnd_d      = ohnd_q;
    oarg_d      = oarg_q;
    opend_d     = opend_q;
    olast_d     = olast_q;
    if (emit) begin
      out_valid_d = 1'b1;
      kind_d      = e_kind;
      ohnd_d      = e_hnd;
      oarg_d      = e_arg;
      opend_d     = PEND_W'(e_pend);
      olast_d     = e_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    pos_q      <= pos_d;
    acc_q      <= acc_d;
    rest_q     <= rest_d;
    nexp_q     <= nexp_d;
    delay_q    <= delay_d;
    hnd_q      <= hnd_d;
    arg_q      <= arg_d;
    pend_hnd_q <= pend_hnd_d;
    pend_arg_q <= pend_arg_d;
    kind_q     <= kind_d;
    ohnd_q     <= ohnd_d;
    oarg_q     <= oarg_d;
    opend_q    <= opend_d;
    olast_q    <= olast_d;
  end

  assign out_valid_o        = out_valid_q;
  assign event_kind_o       = kind_q;
  assign expired_handler_o  = ohnd_q;
  assign expired_argument_o = oarg_q;
  assign pending_count_o    = opend_q;
  assign last_o             = olast_q;

endmodule

// ----- sim/tb_delta_list_timer_queue_unit.sv -----
// self-checking testbench for the delta list timer queue unit
`timescale 1ns / 100ps

module tb_delta_list_timer_queue_unit;
  import dltq_pkg::*;

  // one request transaction as it sits on the input ports
  typedef struct packed {
    logic                      req;
    logic [DELAY_BITS_DEF-1:0] delay;
    logic [HND_W-1:0]          hnd;
    logic [ARG_W-1:0]          arg;
  } timer_req_t;

  // one result transaction as it leaves the block
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [HND_W-1:0]  hnd;
    logic [ARG_W-1:0]  arg;
    logic [PEND_W-1:0] pend;
    logic              last;
  } timer_event_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request channel, driven by the tb
  logic                      in_valid  = 1'b0;
  logic                      in_stall_o;
  logic                      req_type  = REQ_TICK;
  logic [DELAY_BITS_DEF-1:0] delay_ticks = '0;
  logic [HND_W-1:0]          handler_id  = '0;
  logic [ARG_W-1:0]          task_argument = '0;

  // result channel
  logic              out_valid_o;
  logic              out_stall = 1'b1;
  logic [KIND_W-1:0] event_kind_o;
  logic [HND_W-1:0]  expired_handler_o;
  logic [ARG_W-1:0]  expired_argument_o;
  logic [PEND_W-1:0] pending_count_o;
  logic              last_o;

  // stimulus waiting to go out, and results the block still owes us
  timer_req_t   pending_requests[$];
  timer_event_t expected_events[$];
  timer_req_t   next_request;
  timer_event_t wanted_event;

  // shadow copy of the delta list, slot 0 is the head
  logic [DELAY_BITS_DEF-1:0] slot_delta[QUEUE_DEPTH_DEF];
  logic [HND_W-1:0]          slot_handler[QUEUE_DEPTH_DEF];
  logic [ARG_W-1:0]          slot_arg[QUEUE_DEPTH_DEF];
  int                        queued_tasks = 0;

  // handshake pressure, percent of cycles each side holds back
  int sender_idle_pct   = 19;
  int receiver_idle_pct = 83;

  int error_count    = 0;
  int requests_sent  = 0;
  int ticks_sent     = 0;
  int adds_accepted  = 0;
  int adds_rejected  = 0;
  int tasks_expired  = 0;

  always #5 clk_i = ~clk_i;

  delta_list_timer_queue_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type),
    .delay_ticks_i      (delay_ticks),
    .handler_id_i       (handler_id),
    .task_argument_i    (task_argument),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .event_kind_o       (event_kind_o),
    .expired_handler_o  (expired_handler_o),
    .expired_argument_o (expired_argument_o),
    .pending_count_o    (pending_count_o),
    .last_o             (last_o)
  );

  task automatic report_mismatch(input string msg);
    $display("error at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // advance the shadow delta list by one accepted request and queue the
  // results it has to produce, in order
  function automatic void forecast_timer_events(input timer_req_t rq);
    int unsigned               acc;
    int                        pos;
    int                        i;
    int                        n;
    logic [DELAY_BITS_DEF-1:0] rest;
    timer_event_t              ev;
    ev = '0;
    if (rq.req == REQ_ADD) begin
      if (queued_tasks >= QUEUE_DEPTH_DEF) begin
        // full queue, store untouched
        ev.kind = EV_ADD_FULL;
      end else begin
        // walk the deltas until the new delay is passed; ties go behind
        acc = 0;
        pos = queued_tasks;
        for (i = 0; i < queued_tasks; i++) begin
          if (acc + slot_delta[i] > rq.delay) begin
            pos = i;
            break;
          end
          acc += slot_delta[i];
        end
        rest = DELAY_BITS_DEF'(rq.delay - acc);
        // the follower now counts from the new task's expiry
        if (pos < queued_tasks) slot_delta[pos] = slot_delta[pos] - rest;
        for (i = queued_tasks; i > pos; i--) begin
          slot_delta[i]   = slot_delta[i-1];
          slot_handler[i] = slot_handler[i-1];
          slot_arg[i]     = slot_arg[i-1];
        end
        slot_delta[pos]   = rest;
        slot_handler[pos] = rq.hnd;
        slot_arg[pos]     = rq.arg;
        queued_tasks++;
        ev.kind = EV_ADD_OK;
      end
      ev.pend = PEND_W'(queued_tasks);
      ev.last = 1'b1;
      expected_events.push_back(ev);
    end else if (queued_tasks != 0) begin
      // head never counts below zero; a due head expires on this tick
      if (slot_delta[0] != 0) slot_delta[0] = slot_delta[0] - 1'b1;
      n = 0;
      while (queued_tasks > 0 && slot_delta[0] == 0 && n < MAX_RESULTS) begin
        ev.kind = EV_EXPIRED;
        ev.hnd  = slot_handler[0];
        ev.arg  = slot_arg[0];
        for (i = 1; i < queued_tasks; i++) begin
          slot_delta[i-1]   = slot_delta[i];
          slot_handler[i-1] = slot_handler[i];
          slot_arg[i-1]     = slot_arg[i];
        end
        queued_tasks--;
        n++;
        ev.pend = PEND_W'(queued_tasks);
        // last when the loop is about to stop
        ev.last = !(queued_tasks > 0 && slot_delta[0] == 0 && n < MAX_RESULTS);
        expected_events.push_back(ev);
      end
    end
  endfunction

  function automatic void push_add(input logic [DELAY_BITS_DEF-1:0] delay,
                                   input logic [HND_W-1:0] hnd,
                                   input logic [ARG_W-1:0] arg);
    timer_req_t rq;
    rq.req   = REQ_ADD;
    rq.delay = delay;
    rq.hnd   = hnd;
    rq.arg   = arg;
    pending_requests.push_back(rq);
  endfunction

  // payload of a tick is don't care, fill it with noise anyway
  function automatic void push_tick();
    timer_req_t rq;
    rq.req   = REQ_TICK;
    rq.delay = DELAY_BITS_DEF'($urandom);
    rq.hnd   = HND_W'($urandom);
    rq.arg   = $urandom;
    pending_requests.push_back(rq);
  endfunction

  // driver: hold a transaction until it is taken, then maybe idle before
  // the next one; the forecast runs at the edge that accepts it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        next_request.req   = req_type;
        next_request.delay = delay_ticks;
        next_request.hnd   = handler_id;
        next_request.arg   = task_argument;
        forecast_timer_events(next_request);
        requests_sent++;
        if (req_type == REQ_TICK) ticks_sent++;
      end
      // a stalled payload stays put
      if (!in_valid || !in_stall_o) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_request  = pending_requests.pop_front();
          in_valid      <= 1'b1;
          req_type      <= next_request.req;
          delay_ticks   <= next_request.delay;
          handler_id    <= next_request.hnd;
          task_argument <= next_request.arg;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each accepted result against the oldest forecast
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b1;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding, kind %0d handler %0d",
                                    event_kind_o, expired_handler_o));
        end else begin
          wanted_event = expected_events.pop_front();
          if (event_kind_o !== wanted_event.kind)
            report_mismatch($sformatf("event_kind %0d, want %0d",
                                      event_kind_o, wanted_event.kind));
          if (expired_handler_o !== wanted_event.hnd)
            report_mismatch($sformatf("expired_handler %0d, want %0d",
                                      expired_handler_o, wanted_event.hnd));
          if (expired_argument_o !== wanted_event.arg)
            report_mismatch($sformatf("expired_argument %h, want %h",
                                      expired_argument_o, wanted_event.arg));
          if (pending_count_o !== wanted_event.pend)
            report_mismatch($sformatf("pending_count %0d, want %0d",
                                      pending_count_o, wanted_event.pend));
          if (last_o !== wanted_event.last)
            report_mismatch($sformatf("last %0d, want %0d", last_o, wanted_event.last));
          unique case (wanted_event.kind)
            EV_ADD_OK:   adds_accepted++;
            EV_ADD_FULL: adds_rejected++;
            default:     tasks_expired++;
          endcase
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  // let all stimulus go out, then wait for the owed results with a bound,
  // then a pause that covers the slowest tick (sixteen expiries)
  task automatic wait_drained();
    int guard;
    guard = 0;
    while (pending_requests.size() != 0 || in_valid) @(negedge clk_i);
    while (expected_events.size() != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (60) @(negedge clk_i);
  endtask

  initial begin
    int          phase;
    int          i;
    int          k;
    int          d;
    int          r;
    int          items;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (phase = 0; phase < 3; phase++) begin
      @(negedge clk_i);
      // sender light and receiver heavy, then swapped, then no idling
      unique case (phase)
        0: begin
          sender_idle_pct   = 19;
          receiver_idle_pct = 83;
        end
        1: begin
          sender_idle_pct   = 83;
          receiver_idle_pct = 19;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase

      if (phase == 0) begin
        // tick on an empty queue gives nothing
        push_tick();
        // sixteen tied tasks fill the queue; order must be kept on expiry
        for (i = 0; i < QUEUE_DEPTH_DEF; i++) begin
          if (i == 0) push_add(DELAY_BITS_DEF'(3), HND_W'(0), 32'h0000_0000);
          else if (i == QUEUE_DEPTH_DEF - 1)
            push_add(DELAY_BITS_DEF'(3), 8'hff, 32'hffff_ffff);
          else push_add(DELAY_BITS_DEF'(3), HND_W'($urandom), $urandom);
        end
        // add on a full queue is refused
        push_add(DELAY_BITS_DEF'(0), HND_W'($urandom), $urandom);
        // all sixteen come out on the third tick
        push_tick();
        push_tick();
        push_tick();
        // zero delay goes in front of a waiting task and the due head
        // expires on the next tick without counting below zero
        push_add(DELAY_BITS_DEF'(5), HND_W'($urandom), $urandom);
        push_add(DELAY_BITS_DEF'(0), HND_W'($urandom), $urandom);
        push_tick();
        // widest delay, sits behind everything for the rest of the run
        push_add({DELAY_BITS_DEF{1'b1}}, 8'hff, 32'hffff_ffff);
        push_tick();
      end

      // random part: mostly short delays so tasks really expire, bursts of
      // adds for ties and full queues, runs of ticks to drain
      items = 0;
      while (items < 42) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          k = $urandom_range(3, 17);
          d = $urandom_range(0, 6);
          for (i = 0; i < k; i++)
            push_add(DELAY_BITS_DEF'(($urandom_range(0, 1) != 0) ? d : $urandom_range(0, 9)),
                     HND_W'($urandom), $urandom);
          items += k;
        end else if (r < 50) begin
          if (r < 45) d = $urandom_range(0, 7);
          else d = $urandom_range(8, 400);
          push_add(DELAY_BITS_DEF'(d), HND_W'($urandom), $urandom);
          items++;
        end else begin
          k = $urandom_range(1, 6);
          for (i = 0; i < k; i++) push_tick();
          items += k;
        end
      end
      wait_drained();
    end

    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_events.size()));

    $display("ran %0d requests (%0d ticks): %0d adds queued, %0d refused when full, %0d expiries",
             requests_sent, ticks_sent, adds_accepted, adds_rejected, tasks_expired);
    $display("three stall/idle pressure phases, %0d field errors", error_count);
    if (error_count == 0) begin
      $display("delta_list_timer_queue_unit: match");
    end else begin
      $display("delta_list_timer_queue_unit: mismatch");
    end
    $finish;
  end

  // hard stop, several times the slowest legal run
  initial begin
    #20ms;
    $display("timeout, %0d requests still queued, %0d results outstanding",
             pending_requests.size(), expected_events.size());
    $display("delta_list_timer_queue_unit: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/dltq_pkg.sv
sv/dltq_ram.sv
sv/dltq_alu.sv
sv/delta_list_timer_queue_unit.sv
sim/tb_delta_list_timer_queue_unit.sv
